FILE: hdl/homogeneous_vertex_transform_macros.svh
// ----------------------------------------------------------------------------
// homogeneous vertex transform assertion macros
// Wrappers for the concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_MACROS_SVH

`ifndef SYNTHESIS
// check with the reset masking the attempt
`define HVT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds while reset is applied
`define HVT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HVT_ASSERT(lbl, clk, rst, prop, msg)
`define HVT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared constants, register codes and types of the vertex transform.
// ----------------------------------------------------------------------------
`default_nettype none

package hvt_pkg;

   localparam int FIELD_WIDTH     = 32;
   localparam int HALF_WIDTH      = 32;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int NUM_REGS        = 8;
   localparam int REG_INDEX_WIDTH = $clog2(NUM_REGS);
   localparam int ROWS            = 4;
   localparam int COLS            = 4;
   // multiply, pair sum, total and round, saturate
   localparam int PIPE_DEPTH      = 4;

   localparam int DEFAULT_COMPONENT_WIDTH = 32;
   localparam int DEFAULT_FRACTION_BITS   = 16;

   localparam logic [REG_INDEX_WIDTH-1:0] REG_COL0_ROWS01 = 3'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_COL0_ROWS23 = 3'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_COL1_ROWS01 = 3'd2;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_COL1_ROWS23 = 3'd3;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_COL2_ROWS01 = 3'd4;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_COL2_ROWS23 = 3'd5;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_COL3_ROWS01 = 3'd6;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_COL3_ROWS23 = 3'd7;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] value;
      logic                   sat;
   } row_result_type;

   // vector operands must also hold 1.0 for the point-mode w
   function automatic int vec_width(input int cw, input int fb);
      int w;
      w = (cw > fb + 1) ? cw : fb + 2;
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/homogeneous_vertex_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform
// 4x4 column-major matrix times 4-vector in signed fixed point, one item a
// cycle, matrix held in eight 64-bit registers.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  req       start / busy           req_x req_y req_z req_w req_point_mode
//  rsp       rsp_valid (strobe)     rsp_x rsp_y rsp_z rsp_w rsp_saturated
//  csr       csr_valid / csr_ready  csr_index csr_wdata
//
//  an item accepted on start is strobed on the rsp ports once it has passed the
//  pipeline of multiplier, two adder stages and the saturation stage
//  one item enters every cycle; busy and csr_ready never drop
//  synchronous reset clears the valid pipeline and loads the identity matrix
//  the result strobe lasts one cycle and cannot be held off
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_vertex_transform #(
   parameter int COMPONENT_WIDTH = hvt_pkg::DEFAULT_COMPONENT_WIDTH,
   parameter int FRACTION_BITS   = hvt_pkg::DEFAULT_FRACTION_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic signed [hvt_pkg::FIELD_WIDTH-1:0] req_x,
   input  wire logic signed [hvt_pkg::FIELD_WIDTH-1:0] req_y,
   input  wire logic signed [hvt_pkg::FIELD_WIDTH-1:0] req_z,
   input  wire logic signed [hvt_pkg::FIELD_WIDTH-1:0] req_w,
   input  wire logic                                req_point_mode,
   output      logic                                rsp_valid,
   output      logic signed [hvt_pkg::FIELD_WIDTH-1:0] rsp_x,
   output      logic signed [hvt_pkg::FIELD_WIDTH-1:0] rsp_y,
   output      logic signed [hvt_pkg::FIELD_WIDTH-1:0] rsp_z,
   output      logic signed [hvt_pkg::FIELD_WIDTH-1:0] rsp_w,
   output      logic                                rsp_saturated,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [hvt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [hvt_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import hvt_pkg::*;

   `include "homogeneous_vertex_transform_macros.svh"

   localparam int VW = vec_width(COMPONENT_WIDTH, FRACTION_BITS);
   localparam logic [HALF_WIDTH-1:0] ONE_FIX = HALF_WIDTH'(1) << FRACTION_BITS;
   localparam logic signed [VW-1:0]  ONE_VEC = VW'(1) << FRACTION_BITS;
   localparam logic [HALF_WIDTH-1:0] ZERO_HALF = '0;

   function automatic logic [NUM_REGS-1:0][CSR_DATA_WIDTH-1:0] identity_matrix();
      logic [NUM_REGS-1:0][CSR_DATA_WIDTH-1:0] m;
      m                  = '0;
      m[REG_COL0_ROWS01] = {ZERO_HALF, ONE_FIX};
      m[REG_COL1_ROWS01] = {ONE_FIX, ZERO_HALF};
      m[REG_COL2_ROWS23] = {ZERO_HALF, ONE_FIX};
      m[REG_COL3_ROWS23] = {ONE_FIX, ZERO_HALF};
      return m;
   endfunction

   localparam logic [NUM_REGS-1:0][CSR_DATA_WIDTH-1:0] IDENTITY = identity_matrix();

   logic                                        req_fire;
   logic                                        csr_fire;
   logic                                        csr_drop;
   logic [NUM_REGS-1:0][CSR_DATA_WIDTH-1:0]     m_regs_in;
   logic [NUM_REGS-1:0][CSR_DATA_WIDTH-1:0]     m_regs_ff;
   logic [PIPE_DEPTH-1:0]                       vld_in;
   logic [PIPE_DEPTH-1:0]                       vld_ff;
   logic [PIPE_DEPTH-1:0]                       point_in;
   logic [PIPE_DEPTH-1:0]                       point_ff;
   logic signed [VW-1:0]                        vec [COLS];
   row_result_type                              row_res [ROWS];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign req_fire  = start && !busy;
   assign csr_fire  = csr_valid && csr_ready;
   assign csr_drop  = csr_fire && (csr_index >= CSR_INDEX_WIDTH'(NUM_REGS));

   // matrix registers, writes past the register list are dropped
   always_comb begin
      m_regs_in = m_regs_ff;
      if (csr_fire && (csr_index < CSR_INDEX_WIDTH'(NUM_REGS))) begin
         m_regs_in[csr_index[REG_INDEX_WIDTH-1:0]] = csr_wdata;
      end
   end

   always_comb begin
      vld_in   = {vld_ff[PIPE_DEPTH-2:0], req_fire};
      point_in = {point_ff[PIPE_DEPTH-2:0], req_point_mode};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_regs_ff <= IDENTITY;
         vld_ff    <= '0;
      end else begin
         m_regs_ff <= m_regs_in;
         vld_ff    <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
   end

   // vector operands, w replaced by 1.0 for points
   always_comb begin
      vec[0] = VW'($signed(req_x[COMPONENT_WIDTH-1:0]));
      vec[1] = VW'($signed(req_y[COMPONENT_WIDTH-1:0]));
      vec[2] = VW'($signed(req_z[COMPONENT_WIDTH-1:0]));
      if (req_point_mode) begin
         vec[3] = ONE_VEC;
      end else begin
         vec[3] = VW'($signed(req_w[COMPONENT_WIDTH-1:0]));
      end
   end

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      logic signed [COMPONENT_WIDTH-1:0] elem [COLS];

      for (genvar c = 0; c < COLS; c++) begin : g_col
         assign elem[c] =
            m_regs_ff[(c << 1) | (r >> 1)][(r & 1) * HALF_WIDTH +: COMPONENT_WIDTH];
      end

      hvt_row_dot #(
         .COMPONENT_WIDTH (COMPONENT_WIDTH),
         .FRACTION_BITS   (FRACTION_BITS),
         .VEC_WIDTH       (VW)
      ) u_row (
         .clock  (clock),
         .elem   (elem),
         .vec    (vec),
         .result (row_res[r])
      );
   end

   assign rsp_valid     = vld_ff[PIPE_DEPTH-1];
   assign rsp_x         = row_res[0].value;
   assign rsp_y         = row_res[1].value;
   assign rsp_z         = row_res[2].value;
   assign rsp_w         = point_ff[PIPE_DEPTH-1] ? '0 : row_res[3].value;
   // the w row counts only for full four-vectors
   assign rsp_saturated = row_res[0].sat || row_res[1].sat || row_res[2].sat ||
                          (row_res[3].sat && !point_ff[PIPE_DEPTH-1]);

   `HVT_ASSERT(a_item_out, clock, reset, req_fire |-> ##4 rsp_valid, "accepted item lost")
   `HVT_ASSERT(a_no_spurious, clock, reset, rsp_valid |-> $past(req_fire, 4), "stray result")
   `HVT_ASSERT(a_bad_index, clock, reset, csr_drop |=> m_regs_ff == $past(m_regs_ff), "bad write")

endmodule

`default_nettype wire

FILE: hdl/hvt_row_dot.sv
// ----------------------------------------------------------------------------
// hvt_row_dot
// One matrix row times the vector: four products, adder tree, rounding and
// saturation over four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_row_dot #(
   parameter int COMPONENT_WIDTH = 32,
   parameter int FRACTION_BITS   = 16,
   parameter int VEC_WIDTH       = 32
) (
   input  wire logic                               clock,
   input  wire logic signed [COMPONENT_WIDTH-1:0]  elem [hvt_pkg::COLS],
   input  wire logic signed [VEC_WIDTH-1:0]        vec  [hvt_pkg::COLS],
   output hvt_pkg::row_result_type                 result
);
   import hvt_pkg::*;

   localparam int PW = COMPONENT_WIDTH + VEC_WIDTH;
   localparam int SW = PW + 1;
   localparam int TW = PW + 2;
   localparam int RW = TW - FRACTION_BITS;
   localparam int CW_HI = COMPONENT_WIDTH - 1;
   localparam logic signed [TW-1:0] HALF = TW'(1) << (FRACTION_BITS - 1);

   logic signed [PW-1:0] prod_in [COLS];
   logic signed [PW-1:0] prod_ff [COLS];
   logic signed [SW-1:0] pair_in [2];
   logic signed [SW-1:0] pair_ff [2];
   logic signed [TW-1:0] total_in;
   logic signed [TW-1:0] total_ff;
   logic [RW-1:0]        rounded;
   logic [RW-CW_HI-1:0]  upper;
   row_result_type       result_in;
   row_result_type       result_ff;
   logic [COMPONENT_WIDTH-1:0] limit;

   always_comb begin
      for (int c = 0; c < COLS; c++) begin
         prod_in[c] = PW'(elem[c]) * PW'(vec[c]);
      end
      pair_in[0] = SW'(prod_ff[0]) + SW'(prod_ff[1]);
      pair_in[1] = SW'(prod_ff[2]) + SW'(prod_ff[3]);
      total_in   = TW'(pair_ff[0]) + TW'(pair_ff[1]) + HALF;
   end

   // floor of the half-up sum, then clip to the component range
   always_comb begin
      rounded = total_ff[TW-1:FRACTION_BITS];
      upper   = rounded[RW-1:CW_HI];
      limit   = {rounded[RW-1], {CW_HI{~rounded[RW-1]}}};
      if ((&upper) || !(|upper)) begin
         result_in.value = FIELD_WIDTH'($signed(rounded[COMPONENT_WIDTH-1:0]));
         result_in.sat   = 1'b0;
      end else begin
         result_in.value = FIELD_WIDTH'($signed(limit));
         result_in.sat   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      pair_ff   <= pair_in;
      total_ff  <= total_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire
